// File: rtl/core/ladder_keypad_click_hold_defines.svh
// Assertion macros for the ladder keypad decoder.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef LADDER_KEYPAD_CLICK_HOLD_DEFINES_SVH
`define LADDER_KEYPAD_CLICK_HOLD_DEFINES_SVH

// same-cycle implication
`define LKCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lkch_pkg.sv
// Shared types and constants for the ladder keypad decoder.
// No dependencies.
package lkch_pkg;

  localparam int unsigned ADC_BITS_DEF = 10;
  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned LEVEL_W      = 10;
  localparam int unsigned OFFSET_W     = 9;
  localparam int unsigned DELAY_W      = 16;
  localparam int unsigned PHASE_W      = 8;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned BTN_W        = 3;
  localparam int unsigned NUM_LEVELS   = 4;
  localparam int unsigned NUM_LANES    = 2;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [BTN_W-1:0] BTN_NONE = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_DELAY   = 3'd0,
    CFG_REPEAT_IVAL  = 3'd1,
    CFG_WIN_OFFSET   = 3'd2,
    CFG_LEVEL_ONE    = 3'd3,
    CFG_LEVEL_TWO    = 3'd4,
    CFG_LEVEL_THREE  = 3'd5,
    CFG_LEVEL_FOUR   = 3'd6
  } cfg_idx_e;

  localparam logic [DELAY_W-1:0]  RST_HOLD_DELAY  = 16'd1000;
  localparam logic [PHASE_W-1:0]  RST_REPEAT_IVAL = 8'd4;
  localparam logic [OFFSET_W-1:0] RST_WIN_OFFSET  = 9'd50;
  localparam logic [NUM_LEVELS-1:0][LEVEL_W-1:0] RST_LEVELS =
    {10'd502, 10'd351, 10'd150, 10'd0};

  typedef struct packed {
    logic [DELAY_W-1:0]                   hold_delay_ms;
    logic [PHASE_W-1:0]                   repeat_interval;
    logic [OFFSET_W-1:0]                  window_offset;
    logic [NUM_LEVELS-1:0][LEVEL_W-1:0]   levels;
  } cfg_t;

endpackage

// File: rtl/core/lkch_if.sv
// Handshake channel interfaces: poll input, event output, register writes.
// Depends on lkch_pkg.
interface lkch_in_if;
  import lkch_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_first;
  logic [SAMPLE_W-1:0] sample_second;
  logic [TIME_W-1:0]   now_ms;
  modport source (output valid, sample_first, sample_second, now_ms, input ready);
  modport sink   (input valid, sample_first, sample_second, now_ms, output ready);
endinterface

interface lkch_out_if;
  import lkch_pkg::*;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_event;
  modport source (output valid, button_event, input ready);
  modport sink   (input valid, button_event, output ready);
endinterface

interface lkch_cfg_if;
  import lkch_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/lkch_lane.sv
// One classifier lane: matches a sample against the four level windows.
// Depends on lkch_pkg.
module lkch_lane #(
  parameter int unsigned AdcBits = lkch_pkg::ADC_BITS_DEF
) (
  input  lkch_pkg::cfg_t                   cfg_i,
  input  logic [lkch_pkg::SAMPLE_W-1:0]    sample_i,
  output logic [lkch_pkg::BTN_W-1:0]       button_o
);
  import lkch_pkg::*;

  localparam int unsigned CmpW = ((AdcBits > LEVEL_W) ? AdcBits : LEVEL_W) + 2;
  localparam logic [CmpW-1:0] AdcMax = CmpW'((1 << AdcBits) - 1);

  logic [CmpW-1:0]       smp;
  logic [CmpW-1:0]       ofs;
  logic [NUM_LEVELS-1:0] hit;

  assign smp = CmpW'(sample_i) & AdcMax;
  assign ofs = CmpW'(cfg_i.window_offset);

  always_comb begin
    logic [CmpW-1:0] lvl;
    logic            lo_ok;
    logic            hi_ok;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl    = CmpW'(cfg_i.levels[i]);
      lo_ok  = (lvl <= ofs) || ((smp + ofs) > lvl);
      hi_ok  = ((lvl + ofs) >= AdcMax) || (smp < (lvl + ofs));
      hit[i] = lo_ok && hi_ok;
    end
  end

  // first window in order wins
  always_comb begin
    button_o = BTN_NONE;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        button_o = BTN_W'(i + 1);
      end
    end
  end

endmodule

// File: rtl/core/lkch_tracker.sv
// Merges the lane results and tracks press, release and hold repeat state.
// Also re-reduces the repeat phase after the interval register changes.
// Depends on lkch_pkg.
module lkch_tracker (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  lkch_pkg::cfg_t                            cfg_i,
  input  logic                                      ival_wr_i,
  input  logic                                      accept_i,
  input  logic [lkch_pkg::NUM_LANES-1:0][lkch_pkg::BTN_W-1:0] lane_btn_i,
  input  logic [lkch_pkg::TIME_W-1:0]               now_i,
  output logic [lkch_pkg::BTN_W-1:0]                event_o,
  output logic                                      busy_o
);
  import lkch_pkg::*;

  localparam int unsigned CntW = $clog2(PHASE_W);

  logic [BTN_W-1:0]   last_q, last_d;
  logic [TIME_W-1:0]  start_q, start_d;
  logic               timing_q, timing_d;
  logic               hold_q, hold_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  // phase reduced modulo the current interval
  logic [PHASE_W-1:0] red_q, red_d;

  logic               busy_q;
  logic [CntW-1:0]    cnt_q;
  logic [PHASE_W-1:0] rem_q;

  logic [BTN_W-1:0]   button;
  logic [TIME_W-1:0]  elapsed;
  logic               held;
  logic [PHASE_W-1:0] ival;
  logic [PHASE_W:0]   ph_inc;
  logic [PHASE_W-1:0] ph_next;
  logic [PHASE_W:0]   rem_sh;
  logic [PHASE_W:0]   rem_nx;

  assign button  = (lane_btn_i[0] == lane_btn_i[1]) ? lane_btn_i[0] : BTN_NONE;
  assign elapsed = now_i - start_q;
  assign held    = timing_q && (elapsed > TIME_W'(cfg_i.hold_delay_ms));
  assign ival    = (cfg_i.repeat_interval == '0) ? PHASE_W'(1) : cfg_i.repeat_interval;
  assign ph_inc  = {1'b0, red_q} + (PHASE_W+1)'(1);
  assign ph_next = (ph_inc >= {1'b0, ival}) ? '0 : ph_inc[PHASE_W-1:0];

  // restoring remainder, one phase bit per cycle
  assign rem_sh = {rem_q, phase_q[cnt_q]};
  assign rem_nx = (rem_sh >= {1'b0, ival}) ? (rem_sh - {1'b0, ival}) : rem_sh;

  always_comb begin
    last_d   = last_q;
    start_d  = start_q;
    timing_d = timing_q;
    hold_d   = hold_q;
    phase_d  = phase_q;
    red_d    = red_q;
    event_o  = BTN_NONE;
    priority if (button == BTN_NONE && last_q != BTN_NONE) begin
      event_o  = hold_q ? BTN_NONE : last_q;
      last_d   = BTN_NONE;
      start_d  = '0;
      timing_d = 1'b0;
      hold_d   = 1'b0;
      phase_d  = '0;
      red_d    = '0;
    end else if (button != BTN_NONE) begin
      if (held) begin
        hold_d  = 1'b1;
        phase_d = ph_next;
        red_d   = ph_next;
        if (red_q == '0) begin
          event_o = button;
        end else begin
          last_d = button;
        end
      end else begin
        if (!timing_q) begin
          start_d  = now_i;
          timing_d = 1'b1;
        end
        last_d = button;
      end
    end else begin
      last_d = button;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= BTN_NONE;
      start_q  <= '0;
      timing_q <= 1'b0;
      hold_q   <= 1'b0;
      phase_q  <= '0;
      red_q    <= '0;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
    end else begin
      priority if (ival_wr_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(PHASE_W - 1);
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_nx[PHASE_W-1:0];
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          red_q  <= rem_nx[PHASE_W-1:0];
          busy_q <= 1'b0;
        end
      end else if (accept_i) begin
        last_q   <= last_d;
        start_q  <= start_d;
        timing_q <= timing_d;
        hold_q   <= hold_d;
        phase_q  <= phase_d;
        red_q    <= red_d;
      end
    end
  end

  assign busy_o = busy_q;

endmodule

// File: rtl/core/ladder_keypad_click_hold.sv
// Ladder keypad click/hold decoder, top level: register file, two classifier lanes,
// tracker and a two-entry output buffer. A poll's event is registered into the output
// register, or the skid entry if it is full. Throughput: one poll per cycle while the
// skid entry is empty and no re-reduction runs; a repeat_interval write stalls input
// in its own cycle and during the phase re-reduction after it. Reset (rst_ni, async,
// active low) restores register defaults, clears all key state and the output buffer.
`include "ladder_keypad_click_hold_defines.svh"

module ladder_keypad_click_hold #(
  parameter int unsigned AdcBits = lkch_pkg::ADC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lkch_in_if.sink     in_i,
  lkch_cfg_if.sink    cfg_i,
  lkch_out_if.source  out_o
);
  import lkch_pkg::*;

  cfg_t cfg_q;
  logic ival_wr;
  logic busy;
  logic accept;

  logic [NUM_LANES-1:0][SAMPLE_W-1:0] samples;
  logic [NUM_LANES-1:0][BTN_W-1:0]    lane_btn;
  logic [BTN_W-1:0]                   event_new;

  logic             o_valid_q, s_valid_q;
  logic [BTN_W-1:0] o_data_q, s_data_q;
  logic             pop;

  // register writes
  assign cfg_i.ready = 1'b1;
  assign ival_wr = cfg_i.valid && (cfg_idx_e'(cfg_i.index) == CFG_REPEAT_IVAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_delay_ms   <= RST_HOLD_DELAY;
      cfg_q.repeat_interval <= RST_REPEAT_IVAL;
      cfg_q.window_offset   <= RST_WIN_OFFSET;
      cfg_q.levels          <= RST_LEVELS;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_HOLD_DELAY:  cfg_q.hold_delay_ms   <= cfg_i.data[DELAY_W-1:0];
        CFG_REPEAT_IVAL: cfg_q.repeat_interval <= cfg_i.data[PHASE_W-1:0];
        CFG_WIN_OFFSET:  cfg_q.window_offset   <= cfg_i.data[OFFSET_W-1:0];
        CFG_LEVEL_ONE:   cfg_q.levels[0]       <= cfg_i.data[LEVEL_W-1:0];
        CFG_LEVEL_TWO:   cfg_q.levels[1]       <= cfg_i.data[LEVEL_W-1:0];
        CFG_LEVEL_THREE: cfg_q.levels[2]       <= cfg_i.data[LEVEL_W-1:0];
        CFG_LEVEL_FOUR:  cfg_q.levels[3]       <= cfg_i.data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // classifier lanes
  assign samples[0] = in_i.sample_first;
  assign samples[1] = in_i.sample_second;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lkch_lane #(
      .AdcBits (AdcBits)
    ) u_lane (
      .cfg_i    (cfg_q),
      .sample_i (samples[g]),
      .button_o (lane_btn[g])
    );
  end

  assign in_i.ready = !s_valid_q && !busy && !ival_wr;
  assign accept     = in_i.valid && in_i.ready;

  lkch_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .ival_wr_i  (ival_wr),
    .accept_i   (accept),
    .lane_btn_i (lane_btn),
    .now_i      (in_i.now_ms),
    .event_o    (event_new),
    .busy_o     (busy)
  );

  // output register plus skid entry
  assign pop = o_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (s_valid_q) begin
          s_valid_q <= 1'b0;
        end else begin
          o_valid_q <= accept;
        end
      end else if (accept) begin
        if (!o_valid_q) begin
          o_valid_q <= 1'b1;
        end else begin
          s_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && s_valid_q) begin
      o_data_q <= s_data_q;
    end else if (accept && (pop || !o_valid_q)) begin
      o_data_q <= event_new;
    end
    if (accept && o_valid_q && !pop) begin
      s_data_q <= event_new;
    end
  end

  assign out_o.valid        = o_valid_q;
  assign out_o.button_event = o_data_q;

  `LKCH_ASSERT_NOW(a_skid_behind_out, s_valid_q, o_valid_q, "skid entry without output entry")
  `LKCH_ASSERT_NEXT(a_poll_gives_event, accept, o_valid_q, "accepted poll left no event")
  `LKCH_ASSERT_NOW(a_no_poll_when_busy, busy, !accept, "poll taken during phase reduction")

endmodule
